// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the queue and back-end RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every rising clock edge outside reset
`define TWTD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must never be true outside reset
`define TWTD_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TWTD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWTD_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- sv/twtd_pkg.sv -----
`default_nettype none
package twtd_pkg;

  // default field widths
  localparam int TIME_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int TIME_BITS_MAX = 32;

  // fixed widths
  localparam int GAIN_BITS      = 16;
  localparam int DIST_BITS      = 48;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_ON_TIME  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_EARLY    = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_LATE     = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDEST_WINDOW = 8'd3;

  // register reset values
  localparam logic [GAIN_BITS-1:0] GAIN_ON_TIME_RST = 16'd256;
  localparam logic [GAIN_BITS-1:0] GAIN_EARLY_RST   = 16'd384;
  localparam logic [GAIN_BITS-1:0] GAIN_LATE_RST    = 16'd512;

  // configuration seen by the datapath
  typedef struct packed {
    logic [GAIN_BITS-1:0]     k1;
    logic [GAIN_BITS-1:0]     k2;
    logic [GAIN_BITS-1:0]     k3;
    logic [TIME_BITS_MAX-1:0] widest;
  } cfg_t;

endpackage
`default_nettype wire

// ----- sv/twtd_front.sv -----
`default_nettype none
module twtd_front #(
  parameter int TIME_BITS = twtd_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = twtd_pkg::FRAC_BITS_DEF,
  localparam int TW = TIME_BITS + FRAC_BITS + 2,
  localparam int IW = 8 * TW + TIME_BITS + 2
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [twtd_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire logic [twtd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output twtd_pkg::cfg_t                            cfg_o,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [TIME_BITS-1:0]                 from_open_i,
  input  wire logic [TIME_BITS-1:0]                 from_close_i,
  input  wire logic [TIME_BITS-1:0]                 from_service_i,
  input  wire logic [TIME_BITS+FRAC_BITS-1:0]       travel_time_i,
  input  wire logic [TIME_BITS-1:0]                 to_open_i,
  input  wire logic [TIME_BITS-1:0]                 to_close_i,
  input  wire logic                                 room_i,
  output logic                                      push_o,
  output logic [IW-1:0]                             item_o
);

  logic [twtd_pkg::GAIN_BITS-1:0] k1_q, k2_q, k3_q;
  logic [TIME_BITS-1:0]           ww_q;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= twtd_pkg::GAIN_ON_TIME_RST;
      k2_q <= twtd_pkg::GAIN_EARLY_RST;
      k3_q <= twtd_pkg::GAIN_LATE_RST;
      ww_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        twtd_pkg::REG_GAIN_ON_TIME:  k1_q <= cfg_data_i[twtd_pkg::GAIN_BITS-1:0];
        twtd_pkg::REG_GAIN_EARLY:    k2_q <= cfg_data_i[twtd_pkg::GAIN_BITS-1:0];
        twtd_pkg::REG_GAIN_LATE:     k3_q <= cfg_data_i[twtd_pkg::GAIN_BITS-1:0];
        twtd_pkg::REG_WIDEST_WINDOW: ww_q <= cfg_data_i[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.k1     = k1_q;
    cfg_o.k2     = k2_q;
    cfg_o.k3     = k3_q;
    cfg_o.widest = twtd_pkg::TIME_BITS_MAX'(ww_q);
  end

  // shifted departure window and clamped integral bounds
  logic [TW-1:0]            a_t, b_t, m0, m1;
  logic [TW-1:0]            e0, e1, g0, g1, l0, l1, mn1b, mx0a;
  logic signed [TIME_BITS:0] w_t;

  always_comb begin
    a_t = TW'({to_open_i, {FRAC_BITS{1'b0}}});
    b_t = TW'({to_close_i, {FRAC_BITS{1'b0}}});
    m0  = TW'({(TIME_BITS+1)'(from_open_i) + (TIME_BITS+1)'(from_service_i),
               {FRAC_BITS{1'b0}}}) + TW'(travel_time_i);
    m1  = TW'({(TIME_BITS+1)'(from_close_i) + (TIME_BITS+1)'(from_service_i),
               {FRAC_BITS{1'b0}}}) + TW'(travel_time_i);
    w_t = $signed({1'b0, from_close_i}) - $signed({1'b0, from_open_i});
    e1   = (m1 < a_t) ? m1 : a_t;
    e0   = (m0 < a_t) ? m0 : a_t;
    mn1b = (m1 < b_t) ? m1 : b_t;
    g1   = (mn1b > a_t) ? mn1b : a_t;
    mx0a = (m0 > a_t) ? m0 : a_t;
    g0   = (mx0a < b_t) ? mx0a : b_t;
    l1   = (m1 > b_t) ? m1 : b_t;
    l0   = (m0 > b_t) ? m0 : b_t;
  end

  // one classified item waits here for room in the queue
  logic          fr_vld_q;
  logic [IW-1:0] fr_item_q;
  logic          take;

  assign push_o     = fr_vld_q && room_i;
  assign in_stall_o = fr_vld_q && !room_i;
  assign take       = in_valid_i && !in_stall_o;
  assign item_o     = fr_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else if (take) begin
      fr_vld_q <= 1'b1;
    end else if (push_o) begin
      fr_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fr_item_q <= {(w_t == '0), w_t, b_t, a_t, l1, l0, g1, g0, e1, e0};
    end
  end

endmodule
`default_nettype wire

// ----- sv/twtd_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"
module twtd_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  room_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  // two-entry queue between front and back
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign empty_o = (cnt_q == 2'd0);
  assign pop     = pop_i && !empty_o;
  assign room_o  = (cnt_q != 2'd2) || pop;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop)    rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `TWTD_ASSERT(a_push_room, clk_i, rst_ni, push_i |-> room_o, "push into full queue")
  `TWTD_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3, "queue count out of range")

endmodule
`default_nettype wire

// ----- sv/twtd_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module twtd_back #(
  parameter int TIME_BITS = twtd_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = twtd_pkg::FRAC_BITS_DEF,
  localparam int TW = TIME_BITS + FRAC_BITS + 2,
  localparam int IW = 8 * TW + TIME_BITS + 2
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  twtd_pkg::cfg_t                           cfg_i,
  input  wire logic                                empty_i,
  input  wire logic [IW-1:0]                       item_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [twtd_pkg::DIST_BITS-1:0]    distance_o,
  output logic                                     zero_width_o
);

  localparam int T   = TIME_BITS;
  localparam int GW  = twtd_pkg::GAIN_BITS;
  localparam int QB  = twtd_pkg::DIST_BITS;
  localparam int PEW = GW + TW + 1;            // gain times sum of bounds
  localparam int PBW = GW + 1 + T + FRAC_BITS; // gain times window edge
  localparam int TBW = GW + TW + 3;            // slope term
  localparam int H   = TBW / 2;                // split point of slope term
  localparam int LW  = TW + H + 2;
  localparam int HW  = TW + 1 + TBW - H;
  localparam int PW  = TW + 1 + TBW;
  localparam int SW  = PW + 2;
  localparam int KW  = GW + T;
  localparam int MWW = KW + T + 2;
  localparam int MSH = MWW + 2 * FRAC_BITS + 1;
  localparam int MW  = ((MSH > SW) ? MSH : SW) + 1;
  localparam int DW  = T + 2 * FRAC_BITS - 6;
  localparam int HIW = MW + 1 - QB;
  localparam int CW  = (HIW > DW) ? HIW : DW;
  localparam logic [QB-1:0] POS_MAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] NEG_MAG = {1'b1, {(QB-1){1'b0}}};

  // whole pipeline moves when the output register can take a result
  logic adv;
  logic out_vld_q;
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv;

  // unpack the queued item
  logic [TW-1:0]            e0, e1, g0, g1, l0, l1, a_t, b_t;
  logic signed [T:0]        w_t;
  logic                     z_t;
  assign e0  = item_i[TW-1:0];
  assign e1  = item_i[2*TW-1:TW];
  assign g0  = item_i[3*TW-1:2*TW];
  assign g1  = item_i[4*TW-1:3*TW];
  assign l0  = item_i[5*TW-1:4*TW];
  assign l1  = item_i[6*TW-1:5*TW];
  assign a_t = item_i[7*TW-1:6*TW];
  assign b_t = item_i[8*TW-1:7*TW];
  assign w_t = $signed(item_i[8*TW+T:8*TW]);
  assign z_t = item_i[8*TW+T+1];

  // stage 1: gain products and bound differences
  logic                    v1_q;
  logic [PEW-1:0]          pe_q, pg_q, pl_q;
  logic [PBW-1:0]          pb1_q, pa_q, pb3_q;
  logic signed [TW:0]      de1_q, dg1_q, dl1_q;
  logic [KW-1:0]           kw_q;
  logic signed [T:0]       w1_q;
  logic                    z1_q;
  logic [GW:0]             k12;
  assign k12 = (GW+1)'(cfg_i.k1) + (GW+1)'(cfg_i.k2);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pe_q  <= cfg_i.k2 * ((TW+1)'(e1) + (TW+1)'(e0));
      pg_q  <= cfg_i.k1 * ((TW+1)'(g1) + (TW+1)'(g0));
      pl_q  <= cfg_i.k3 * ((TW+1)'(l1) + (TW+1)'(l0));
      pb1_q <= cfg_i.k1 * b_t;
      pa_q  <= k12 * a_t;
      pb3_q <= cfg_i.k3 * b_t;
      de1_q <= $signed({1'b0, e1}) - $signed({1'b0, e0});
      dg1_q <= $signed({1'b0, g1}) - $signed({1'b0, g0});
      dl1_q <= $signed({1'b0, l1}) - $signed({1'b0, l0});
      kw_q  <= cfg_i.k1 * cfg_i.widest[T-1:0];
      w1_q  <= w_t;
      z1_q  <= z_t;
    end
  end

  // stage 2: slope terms, on-time gain times width
  logic                    v2_q;
  logic signed [TBW-1:0]   tbe_q, tbg_q, tbl_q;
  logic signed [TW:0]      de2_q, dg2_q, dl2_q;
  logic signed [MWW-1:0]   mw2_q;
  logic signed [T:0]       w2_q;
  logic                    z2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tbe_q <= $signed(TBW'(pe_q)) + $signed(TBW'({pb1_q, 1'b0}))
               - $signed(TBW'({pa_q, 1'b0}));
      tbg_q <= $signed(TBW'({pb1_q, 1'b0})) - $signed(TBW'(pg_q));
      tbl_q <= $signed(TBW'({pb3_q, 1'b0})) - $signed(TBW'(pl_q));
      mw2_q <= $signed({1'b0, kw_q}) * w1_q;
      de2_q <= de1_q;
      dg2_q <= dg1_q;
      dl2_q <= dl1_q;
      w2_q  <= w1_q;
      z2_q  <= z1_q;
    end
  end

  // stage 3: partial products of difference times slope
  logic                    v3_q;
  logic signed [LW-1:0]    ple_q, plg_q, pll_q;
  logic signed [HW-1:0]    phe_q, phg_q, phl_q;
  logic signed [MWW-1:0]   mw3_q;
  logic signed [T:0]       w3_q;
  logic                    z3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ple_q <= de2_q * $signed({1'b0, tbe_q[H-1:0]});
      plg_q <= dg2_q * $signed({1'b0, tbg_q[H-1:0]});
      pll_q <= dl2_q * $signed({1'b0, tbl_q[H-1:0]});
      phe_q <= de2_q * $signed(tbe_q[TBW-1:H]);
      phg_q <= dg2_q * $signed(tbg_q[TBW-1:H]);
      phl_q <= dl2_q * $signed(tbl_q[TBW-1:H]);
      mw3_q <= mw2_q;
      w3_q  <= w2_q;
      z3_q  <= z2_q;
    end
  end

  // stage 4: join partial products
  logic                    v4_q;
  logic signed [PW-1:0]    te_q, tg_q, tl_q;
  logic signed [MWW-1:0]   mw4_q;
  logic signed [T:0]       w4_q;
  logic                    z4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      te_q  <= (PW'(phe_q) <<< H) + PW'(ple_q);
      tg_q  <= (PW'(phg_q) <<< H) + PW'(plg_q);
      tl_q  <= (PW'(phl_q) <<< H) + PW'(pll_q);
      mw4_q <= mw3_q;
      w4_q  <= w3_q;
      z4_q  <= z3_q;
    end
  end

  // stage 5: numerator
  logic                    v5_q;
  logic signed [MW-1:0]    m5_q;
  logic signed [T:0]       w5_q;
  logic                    z5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m5_q <= (MW'(mw4_q) <<< (2 * FRAC_BITS + 1))
              - (MW'(te_q) + MW'(tg_q) + MW'(tl_q));
      w5_q <= w4_q;
      z5_q <= z4_q;
    end
  end

  // stage 6: magnitudes, sign and divisor
  logic                    v6_q;
  logic [MW-1:0]           mabs6_q;
  logic [DW-1:0]           div6_q;
  logic                    neg6_q, z6_q;
  logic [T:0]              wabs;
  assign wabs = w5_q[T] ? (T+1)'(-w5_q) : (T+1)'(w5_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mabs6_q <= m5_q[MW-1] ? MW'(-m5_q) : MW'(m5_q);
      div6_q  <= {wabs, {(2*FRAC_BITS-7){1'b0}}};
      neg6_q  <= m5_q[MW-1] ^ w5_q[T];
      z6_q    <= z5_q;
    end
  end

  // stage 7: rounding offset
  logic                    v7_q;
  logic [MW:0]             mr7_q;
  logic [DW-1:0]           div7_q;
  logic                    neg7_q, z7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr7_q  <= (MW+1)'(mabs6_q) + (MW+1)'(div6_q >> 1);
      div7_q <= div6_q;
      neg7_q <= neg6_q;
      z7_q   <= z6_q;
    end
  end

  // divider: stage 0 checks overflow, then one quotient bit per stage
  logic           dv_vld_q  [QB+1];
  logic [DW-1:0]  dv_rem_q  [QB+1];
  logic [QB-1:0]  dv_low_q  [QB+1];
  logic [QB-1:0]  dv_quo_q  [QB+1];
  logic [DW-1:0]  dv_div_q  [QB+1];
  logic           dv_neg_q  [QB+1];
  logic           dv_ovf_q  [QB+1];
  logic           dv_zero_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q[0]  <= DW'(mr7_q[MW:QB]);
      dv_ovf_q[0]  <= CW'(mr7_q[MW:QB]) >= CW'(div7_q);
      dv_low_q[0]  <= mr7_q[QB-1:0];
      dv_quo_q[0]  <= '0;
      dv_div_q[0]  <= div7_q;
      dv_neg_q[0]  <= neg7_q;
      dv_zero_q[0] <= z7_q;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DW:0] trial;
    logic        ge;
    assign trial = {dv_rem_q[j], dv_low_q[j][QB-1-j]};
    assign ge    = trial >= {1'b0, dv_div_q[j]};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[j+1]  <= ge ? DW'(trial - {1'b0, dv_div_q[j]}) : DW'(trial);
        dv_quo_q[j+1]  <= {dv_quo_q[j][QB-2:0], ge};
        dv_low_q[j+1]  <= dv_low_q[j];
        dv_div_q[j+1]  <= dv_div_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_ovf_q[j+1]  <= dv_ovf_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end
  end

  // valid bits of the fixed stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      dv_vld_q[0] <= 1'b0;
      out_vld_q   <= 1'b0;
    end else if (adv) begin
      v1_q        <= !empty_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      dv_vld_q[0] <= v7_q;
      out_vld_q   <= dv_vld_q[QB];
    end
  end

  // saturation and sign
  logic [QB-1:0] quo, mag;
  logic          sat;
  always_comb begin
    quo = dv_quo_q[QB];
    sat = dv_ovf_q[QB] || (quo[QB-1] && !(dv_neg_q[QB] && quo == NEG_MAG));
    if (sat) begin
      mag = dv_neg_q[QB] ? NEG_MAG : POS_MAX;
    end else begin
      mag = quo;
    end
  end

  logic signed [QB-1:0] dist_q;
  logic                 zw_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zw_q <= dv_zero_q[QB];
      if (dv_zero_q[QB]) begin
        dist_q <= '0;
      end else begin
        dist_q <= dv_neg_q[QB] ? $signed(-mag) : $signed(mag);
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign distance_o   = dist_q;
  assign zero_width_o = zw_q;

  `TWTD_ASSERT(a_zero_dist, clk_i, rst_ni, (out_vld_q && zw_q) |-> (dist_q == '0),
               "zero width result with nonzero distance")
  `TWTD_ASSERT(a_hold_stall, clk_i, rst_ni, (out_vld_q && out_stall_i) |=> $stable(dv_vld_q[QB]),
               "pipeline moved while output stalled")

endmodule
`default_nettype wire

// ----- sv/time_window_temporal_distance.sv -----
// Temporal distance between two nodes under time windows.
// Configuration: write cfg_index_i/cfg_data_i with cfg_valid_i; cfg_ready_o is
// always high. Index 0..3 = gain_on_time, gain_early, gain_late, widest_window;
// other indexes are ignored. Write only while no item is in flight.
// Input channel: one node pair per transfer (in_valid_i high, in_stall_o low).
// Output channel: one distance per input, in order (out_valid_o high,
// out_stall_i low). zero_width_o flags an empty departure window; distance 0.
// Throughput: one item per cycle while the output is not stalled. From input
// transfer to output valid an item passes the input register, the two-entry
// queue, the multiply stages and the 48 one-bit stages of the pipelined divider.
// A stall on the output freezes the back pipeline; the queue and the input
// register keep taking items until they fill, then in_stall_o rises.
// Reset clears all valid bits and loads the register defaults
// (1.0, 1.5, 2.0, 0).
`default_nettype none
module time_window_temporal_distance #(
  parameter int TIME_BITS = twtd_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = twtd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [twtd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [twtd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [TIME_BITS-1:0]                from_open_i,
  input  wire logic [TIME_BITS-1:0]                from_close_i,
  input  wire logic [TIME_BITS-1:0]                from_service_i,
  input  wire logic [TIME_BITS+FRAC_BITS-1:0]      travel_time_i,
  input  wire logic [TIME_BITS-1:0]                to_open_i,
  input  wire logic [TIME_BITS-1:0]                to_close_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [twtd_pkg::DIST_BITS-1:0]    distance_o,
  output logic                                     zero_width_o
);

  localparam int TW = TIME_BITS + FRAC_BITS + 2;
  localparam int IW = 8 * TW + TIME_BITS + 2;

  twtd_pkg::cfg_t cfg;
  logic           room, push, pop, empty;
  logic [IW-1:0]  fr_item, q_item;

  twtd_front #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_o          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .from_open_i    (from_open_i),
    .from_close_i   (from_close_i),
    .from_service_i (from_service_i),
    .travel_time_i  (travel_time_i),
    .to_open_i      (to_open_i),
    .to_close_i     (to_close_i),
    .room_i         (room),
    .push_o         (push),
    .item_o         (fr_item)
  );

  twtd_fifo #(
    .WIDTH (IW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_item),
    .room_o  (room),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_item)
  );

  twtd_back #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .distance_o   (distance_o),
    .zero_width_o (zero_width_o)
  );

endmodule
`default_nettype wire

// ----- dv/time_window_temporal_distance_checker.sv -----
`timescale 1ns / 100ps
module time_window_temporal_distance_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] from_open_i,
  input  logic [15:0] from_close_i,
  input  logic [15:0] from_service_i,
  input  logic [23:0] travel_time_i,
  input  logic [15:0] to_open_i,
  input  logic [15:0] to_close_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic signed [47:0] distance_i,
  input  logic        zero_width_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic signed [47:0] dval;
    logic               zw;
  } dist_result_t;

  localparam wide_t DIST_MAX = 128'sh7FFF_FFFF_FFFF;

  logic [15:0] k_on, k_early, k_late, widest;
  dist_result_t expected_dist_q[$];
  int errs;

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // temporal distance of one node pair under the current gains
  function automatic dist_result_t predict_pair(
      logic [15:0] fo_v, logic [15:0] fc_v, logic [15:0] sv_v,
      logic [23:0] tr_v, logic [15:0] to_v, logic [15:0] tc_v);
    dist_result_t r;
    longint fo, fc, sv, tr, a, b, w, m0, m1, e0, e1, g0, g1, l0, l1;
    wide_t k1, k2, k3, tb, sum, m, dv, q, lim;
    logic neg;
    fo = fo_v; fc = fc_v; sv = sv_v; tr = tr_v;
    a = longint'(to_v) << 8;
    b = longint'(tc_v) << 8;
    k1 = k_on; k2 = k_early; k3 = k_late;
    w = fc - fo;
    r.dval = '0;
    r.zw = 1'b0;
    if (w == 0) begin
      r.zw = 1'b1;
      return r;
    end
    m0 = ((fo + sv) << 8) + tr;
    m1 = ((fc + sv) << 8) + tr;
    e1 = lmin(m1, a);
    e0 = lmin(m0, a);
    g1 = lmax(lmin(m1, b), a);
    g0 = lmin(lmax(m0, a), b);
    l1 = lmax(m1, b);
    l0 = lmax(m0, b);
    // early, on-time and late integrals, each as width times twice the mean slope
    tb = k2 * wide_t'(e1 + e0) + 2 * k1 * wide_t'(b) - 2 * (k1 + k2) * wide_t'(a);
    sum = wide_t'(e1 - e0) * tb;
    tb = 2 * k1 * wide_t'(b) - k1 * wide_t'(g1 + g0);
    sum = sum + wide_t'(g1 - g0) * tb;
    tb = 2 * k3 * wide_t'(b) - k3 * wide_t'(l1 + l0);
    sum = sum + wide_t'(l1 - l0) * tb;
    m = ((k1 * wide_t'(widest) * wide_t'(w)) <<< 17) - sum;
    // round to nearest, ties away from zero, then saturate
    neg = (m < 0) != (w < 0);
    if (m < 0) m = -m;
    dv = wide_t'((w < 0) ? -w : w) <<< 9;
    q = (m + (dv >>> 1)) / dv;
    lim = DIST_MAX + (neg ? 1 : 0);
    if (q > lim) q = lim;
    r.dval = neg ? -q[47:0] : q[47:0];
    return r;
  endfunction

  assign pending_o = expected_dist_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_on <= twtd_pkg::GAIN_ON_TIME_RST;
      k_early <= twtd_pkg::GAIN_EARLY_RST;
      k_late <= twtd_pkg::GAIN_LATE_RST;
      widest <= '0;
      fail_count_o <= 0;
      expected_dist_q.delete();
    end else begin
      errs = 0;
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          twtd_pkg::REG_GAIN_ON_TIME:  k_on <= cfg_data_i[15:0];
          twtd_pkg::REG_GAIN_EARLY:    k_early <= cfg_data_i[15:0];
          twtd_pkg::REG_GAIN_LATE:     k_late <= cfg_data_i[15:0];
          twtd_pkg::REG_WIDEST_WINDOW: widest <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // input transfer: predict
      if (in_valid_i && !in_stall_i)
        expected_dist_q.push_back(predict_pair(from_open_i, from_close_i,
            from_service_i, travel_time_i, to_open_i, to_close_i));
      // output transfer: compare
      if (out_valid_i && !out_stall_i) begin
        if (expected_dist_q.size() == 0) begin
          $display("%0t: unexpected result distance=%0d zero_width=%0b",
                   $time, distance_i, zero_width_i);
          errs = errs + 1;
        end else begin
          dist_result_t e;
          e = expected_dist_q.pop_front();
          if (e.dval !== distance_i) begin
            $display("%0t: distance expected %0d actual %0d", $time, e.dval, distance_i);
            errs = errs + 1;
          end
          if (e.zw !== zero_width_i) begin
            $display("%0t: zero_width expected %0b actual %0b", $time, e.zw, zero_width_i);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

// ----- dv/time_window_temporal_distance_test.sv -----
`timescale 1ns / 100ps
module time_window_temporal_distance_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] from_open = '0, from_close = '0, from_service = '0;
  logic [23:0] travel_time = '0;
  logic [15:0] to_open = '0, to_close = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] distance;
  logic zero_width;
  int fail_count, pending;
  int send_idle_pct = 11, recv_idle_pct = 78;
  int cycles = 0;

  time_window_temporal_distance uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .from_open_i(from_open), .from_close_i(from_close),
    .from_service_i(from_service), .travel_time_i(travel_time),
    .to_open_i(to_open), .to_close_i(to_close),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .distance_o(distance), .zero_width_o(zero_width)
  );

  time_window_temporal_distance_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .from_open_i(from_open), .from_close_i(from_close),
    .from_service_i(from_service), .travel_time_i(travel_time),
    .to_open_i(to_open), .to_close_i(to_close),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .distance_i(distance), .zero_width_i(zero_width),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver back-pressure and run watchdog
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one node pair transfer; valid stays up into the next item
  task automatic send_pair(logic [15:0] fo, logic [15:0] fc, logic [15:0] sv,
                           logic [23:0] tr, logic [15:0] ao, logic [15:0] ac);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    from_open <= fo;
    from_close <= fc;
    from_service <= sv;
    travel_time <= tr;
    to_open <= ao;
    to_close <= ac;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly realistic windows around the arrival time, some raw noise
  task automatic send_random_pair();
    logic [15:0] fo, fc, sv, ao, ac;
    logic [23:0] tr;
    int kind;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_pair(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                16'($urandom), 16'($urandom));
    end else begin
      fo = 16'($urandom_range(20000));
      fc = fo + 16'($urandom_range(300));
      if (kind < 20) fc = fo;
      else if (kind < 25) fc = fo - 16'($urandom_range(300));
      sv = 16'($urandom_range(200));
      tr = 24'($urandom_range(150 * 256));
      ao = fo + sv + 16'(tr >> 8) + 16'($urandom_range(400)) - 16'd200;
      ac = ao + 16'($urandom_range(400));
      if (kind < 30) ac = ao - 16'($urandom_range(200));
      send_pair(fo, fc, sv, tr, ao, ac);
    end
  endtask

  task automatic write_all(logic [15:0] k1, logic [15:0] k2, logic [15:0] k3,
                           logic [15:0] ww);
    write_reg(twtd_pkg::REG_GAIN_ON_TIME, {16'($urandom_range(65535)), k1});
    write_reg(twtd_pkg::REG_GAIN_EARLY, {16'hFFFF, k2});
    write_reg(twtd_pkg::REG_GAIN_LATE, {16'h0000, k3});
    write_reg(twtd_pkg::REG_WIDEST_WINDOW, {16'($urandom_range(65535)), ww});
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs under reset defaults
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 1, 0, 0, 0, 0);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 0, 16'hFFFF);
    send_pair(16'hFFFF, 0, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 0);
    send_pair(100, 200, 10, 50 * 256, 1000, 2000);
    send_pair(100, 200, 10, 50 * 256, 150, 300);
    send_pair(100, 200, 10, 50 * 256, 0, 100);
    send_pair(100, 200, 10, 50 * 256, 170, 320);
    send_pair(200, 100, 10, 50 * 256 + 128, 170, 320);
    send_pair(100, 200, 10, 50 * 256, 320, 170);
    send_pair(100, 200, 0, 24'h0000FF, 100, 100);
    send_pair(5, 5, 3, 24'h000080, 1, 9);
    end_burst();
    wait_idle();

    // extreme gains, ignored index
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(8'd4, 32'h0000_1234);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    send_pair(0, 1, 0, 0, 16'hFFFF, 16'hFFFF);
    send_pair(0, 16'hFFFF, 0, 0, 0, 0);
    send_pair(16'hFFFF, 0, 0, 0, 16'hFFFF, 0);
    send_pair(0, 1, 16'hFFFF, 24'hFFFFFF, 0, 0);
    end_burst();
    wait_idle();
    write_all(0, 0, 0, 0);
    send_pair(0, 10, 0, 0, 5, 8);
    send_pair(0, 10, 0, 0, 16'hFFFF, 16'hFFFF);
    end_burst();
    wait_idle();

    // random phases under several register settings
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin send_idle_pct = 11; recv_idle_pct = 78; end
        2: begin send_idle_pct = 78; recv_idle_pct = 11; end
        4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        default: ;
      endcase
      case (phase)
        0: write_all(twtd_pkg::GAIN_ON_TIME_RST, twtd_pkg::GAIN_EARLY_RST,
                     twtd_pkg::GAIN_LATE_RST, 300);
        1: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        2: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: write_all(16'($urandom_range(1024)), 16'($urandom_range(1024)),
                     16'($urandom_range(1024)), 16'($urandom_range(600)));
        4: write_all(0, 0, 0, 0);
        default: write_all(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
      endcase
      repeat (255) send_random_pair();
      end_burst();
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
